// ----- sv/sspll_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and tables for the SOGI single-phase PLL.
// Used by the multiply-accumulate unit, the CORDIC unit and the top level.
package sspll_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_WIDTH = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_LEN = 24;

  localparam int COEF_FRAC = 29;
  localparam int SMP_FRAC = SAMPLE_WIDTH - 2;
  localparam int ST_FRAC = STATE_WIDTH - 4;
  localparam int SH_OUT = 30 - SMP_FRAC;

  // Multiplier operand and product widths.
  localparam int OPW = 33;
  localparam int PRW = 2 * OPW;
  // Accumulator holds the sum of up to three clipped 32-bit terms.
  localparam int ACCW = 35;

  localparam int NUM_OPS = 13;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [3:0] REG_OSG_B0 = 4'd0;
  localparam logic [3:0] REG_OSG_A1 = 4'd1;
  localparam logic [3:0] REG_OSG_A2 = 4'd2;
  localparam logic [3:0] REG_OSG_QB0 = 4'd3;
  localparam logic [3:0] REG_LOOP_B0 = 4'd4;
  localparam logic [3:0] REG_LOOP_B1 = 4'd5;
  localparam logic [3:0] REG_NOM_FREQ = 4'd6;
  localparam logic [3:0] REG_TIME_STEP = 4'd7;

  typedef enum logic [2:0] {
    SH_SAMPLE, SH_COEF, SH_TRIG, SH_LOOP, SH_PHASE
  } shift_t;

  typedef enum logic [3:0] {
    A_B0, A_A1, A_A2, A_QB0, A_COS, A_SIN, A_LB0, A_LB1, A_FREQ
  } a_sel_t;

  typedef enum logic [3:0] {
    B_XDIFF, B_XSUM, B_AH0, B_AH1, B_BH0, B_BH1, B_Q, B_PQ, B_TS
  } b_sel_t;

  typedef enum logic [1:0] {
    INIT_ZERO, INIT_INTEG, INIT_PHASE
  } init_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_ALPHA, DST_BETA, DST_Q, DST_D, DST_INTEG, DST_PHASE
  } dest_t;

  typedef struct packed {
    shift_t sh;
    logic   sub;
    logic   first;
    logic   wrap;
  } mac_ctl_t;

  typedef struct packed {
    a_sel_t   a;
    b_sel_t   b;
    mac_ctl_t ctl;
    init_t    init;
    dest_t    dst;
  } op_t;

  // Micro-program of the shared multiply-accumulate unit, one entry per product.
  function automatic op_t op_table(input logic [3:0] idx);
    op_t o;
    o = '{a: A_B0, b: B_XDIFF, ctl: '{sh: SH_SAMPLE, sub: 1'b0, first: 1'b1, wrap: 1'b0},
          init: INIT_ZERO, dst: DST_NONE};
    unique case (idx)
      4'd0: ;
      4'd1: begin
        o.a = A_A1; o.b = B_AH0; o.ctl.sh = SH_COEF; o.ctl.first = 1'b0;
      end
      4'd2: begin
        o.a = A_A2; o.b = B_AH1; o.ctl.sh = SH_COEF; o.ctl.first = 1'b0; o.dst = DST_ALPHA;
      end
      4'd3: begin
        o.a = A_QB0; o.b = B_XSUM;
      end
      4'd4: begin
        o.a = A_A1; o.b = B_BH0; o.ctl.sh = SH_COEF; o.ctl.first = 1'b0;
      end
      4'd5: begin
        o.a = A_A2; o.b = B_BH1; o.ctl.sh = SH_COEF; o.ctl.first = 1'b0; o.dst = DST_BETA;
      end
      4'd6: begin
        o.a = A_COS; o.b = B_AH0; o.ctl.sh = SH_TRIG;
      end
      4'd7: begin
        o.a = A_SIN; o.b = B_BH0; o.ctl.sh = SH_TRIG; o.ctl.first = 1'b0; o.dst = DST_Q;
      end
      4'd8: begin
        o.a = A_COS; o.b = B_BH0; o.ctl.sh = SH_TRIG;
      end
      4'd9: begin
        o.a = A_SIN; o.b = B_AH0; o.ctl.sh = SH_TRIG; o.ctl.first = 1'b0;
        o.ctl.sub = 1'b1; o.dst = DST_D;
      end
      4'd10: begin
        o.a = A_LB0; o.b = B_Q; o.ctl.sh = SH_LOOP; o.init = INIT_INTEG;
      end
      4'd11: begin
        o.a = A_LB1; o.b = B_PQ; o.ctl.sh = SH_LOOP; o.ctl.first = 1'b0; o.dst = DST_INTEG;
      end
      4'd12: begin
        o.a = A_FREQ; o.b = B_TS; o.ctl.sh = SH_PHASE; o.ctl.wrap = 1'b1;
        o.init = INIT_PHASE; o.dst = DST_PHASE;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic [31:0] ang_tab(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/sspll_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one registered 33x33 product, then a
// floor shift, 32-bit clip, add or subtract into a 35-bit accumulator.
module sspll_mac (
  input  logic                                 clk,
  input  logic                                 mul_en,
  input  logic                                 acc_en,
  input  sspll_pkg::mac_ctl_t                  ctl,
  input  logic signed [sspll_pkg::OPW-1:0]     a,
  input  logic signed [sspll_pkg::OPW-1:0]     b,
  input  logic signed [sspll_pkg::ACCW-1:0]    init,
  output logic [31:0]                          sum_sat,
  output logic [31:0]                          sum_low
);

  logic signed [sspll_pkg::PRW-1:0]  prod;
  logic signed [sspll_pkg::PRW-1:0]  shv;
  logic signed [31:0]                t;
  logic signed [sspll_pkg::ACCW-1:0] acc;
  logic signed [sspll_pkg::ACCW-1:0] base;
  logic signed [sspll_pkg::ACCW-1:0] acc_next;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= a * b;
    end
    if (acc_en) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    unique case (ctl.sh)
      sspll_pkg::SH_SAMPLE:
        shv = prod >>> (sspll_pkg::COEF_FRAC + sspll_pkg::SMP_FRAC - sspll_pkg::ST_FRAC);
      sspll_pkg::SH_COEF:  shv = prod >>> sspll_pkg::COEF_FRAC;
      sspll_pkg::SH_TRIG:  shv = prod >>> sspll_pkg::SMP_FRAC;
      sspll_pkg::SH_LOOP:  shv = prod >>> (sspll_pkg::ST_FRAC + 5);
      sspll_pkg::SH_PHASE: shv = prod >>> 16;
      default:             shv = prod;
    endcase

    // The phase step wraps; every other term saturates.
    if (ctl.wrap || (shv[sspll_pkg::PRW-1:31] == {(sspll_pkg::PRW-31){shv[31]}})) begin
      t = shv[31:0];
    end else begin
      t = shv[sspll_pkg::PRW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end

    base = ctl.first ? init : acc;
    if (ctl.sub) begin
      acc_next = base - {{(sspll_pkg::ACCW-32){t[31]}}, t};
    end else begin
      acc_next = base + {{(sspll_pkg::ACCW-32){t[31]}}, t};
    end

    if (acc_next[sspll_pkg::ACCW-1:31] == {(sspll_pkg::ACCW-31){acc_next[31]}}) begin
      sum_sat = acc_next[31:0];
    end else begin
      sum_sat = acc_next[sspll_pkg::ACCW-1] ? 32'h80000000 : 32'h7fffffff;
    end
    sum_low = acc_next[31:0];
  end

endmodule

// ----- sv/sspll_cordic.sv -----
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving the
// sine and cosine of a phase in turns. Uses the arctangent table of sspll_pkg.
module sspll_cordic #(
  parameter int CORDIC_STEPS = sspll_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [31:0]                           phase,
  output logic                                  done,
  output logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] sine,
  output logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] cosine
);

  localparam int CW = $clog2(CORDIC_STEPS);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic signed [33:0] x, y, z;
  logic signed [33:0] dx, dy, ang;
  logic [31:0]       pf;

  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    ang = {2'b00, sspll_pkg::ang_tab(5'(cnt))};
    // Second and third quadrants fold by a half turn.
    pf = {phase[31] ^ (phase[31] ^ phase[30]), phase[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= phase[31] ^ phase[30];
        x <= sspll_pkg::CORDIC_GAIN;
        y <= '0;
        z <= {{2{pf[31]}}, pf};
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end
        if (cnt == CW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  function automatic logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] to_out(
    input logic signed [33:0] v, input logic n);
    logic signed [35:0] vn;
    logic signed [35:0] r;
    logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] o;
    vn = n ? -{{2{v[33]}}, v} : {{2{v[33]}}, v};
    r = (vn + (36'sd1 <<< (sspll_pkg::SH_OUT - 1))) >>> sspll_pkg::SH_OUT;
    if (r[35:sspll_pkg::SAMPLE_WIDTH-1] == {(37 - sspll_pkg::SAMPLE_WIDTH){r[35]}}) begin
      o = r[sspll_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      o = r[35] ? {1'b1, {(sspll_pkg::SAMPLE_WIDTH-1){1'b0}}}
                : {1'b0, {(sspll_pkg::SAMPLE_WIDTH-1){1'b1}}};
    end
    return o;
  endfunction

  assign sine = to_out(y, neg);
  assign cosine = to_out(x, neg);

endmodule

// ----- sv/sogi_single_phase_pll.sv -----
`timescale 1ns / 1ps
// SOGI single-phase PLL top level: sequencer, state and configuration registers.
// Thirteen products run through the one shared multiplier, each in a MUL state
// and then an ACC state, after which the CORDIC runs one rotation per cycle. A new
// item is taken while the last result still waits. Synchronous reset clears all loop
// state (cosine too) and sets nominal frequency to 50 Hz and the time step to 1e-4 s.
module sogi_single_phase_pll #(
  parameter int CORDIC_STEPS = sspll_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] grid_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sspll_pkg::STATE_WIDTH-1:0] alpha_out,
  output logic signed [sspll_pkg::STATE_WIDTH-1:0] beta_out,
  output logic signed [sspll_pkg::STATE_WIDTH-1:0] d_term,
  output logic signed [sspll_pkg::STATE_WIDTH-1:0] q_term,
  output logic signed [31:0]                     freq_out,
  output logic [31:0]                            phase_out,
  output logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] sine_out,
  output logic signed [sspll_pkg::SAMPLE_WIDTH-1:0] cosine_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [3:0]                             cfg_index,
  input  logic [31:0]                            cfg_data
);

  localparam int SW = sspll_pkg::SAMPLE_WIDTH;
  localparam int OPW = sspll_pkg::OPW;

  typedef enum logic [2:0] {IDLE, MUL, ACC, CORD, DONE} state_t;

  state_t state;
  logic [3:0] op_idx;
  sspll_pkg::op_t op;

  logic [31:0] osg_b0, osg_a1, osg_a2, osg_qb0, loop_b0, loop_b1, time_step;
  logic [23:0] nominal_freq;

  logic signed [SW-1:0] x0, x1, x2;
  logic signed [31:0] ah0, ah1, bh0, bh1, q_reg, d_reg, prev_q, integ;
  logic [31:0] phase_acc;
  logic signed [SW-1:0] sine_reg, cosine_reg;

  logic signed [OPW-1:0] mac_a, mac_b;
  logic signed [sspll_pkg::ACCW-1:0] mac_init;
  logic [31:0] sum_sat, sum_low;
  logic signed [SW:0] xdiff;
  logic signed [SW+2:0] xsum;
  logic signed [33:0] fsum;
  logic signed [31:0] fo;

  logic cord_start, cord_done;
  logic signed [SW-1:0] cord_sin, cord_cos;

  assign op = sspll_pkg::op_table(op_idx);
  assign cfg_ready = (state == IDLE);
  assign in_ready = (state == IDLE);

  always_comb begin
    xdiff = {x0[SW-1], x0} - {x2[SW-1], x2};
    xsum = {{3{x0[SW-1]}}, x0} + {{2{x1[SW-1]}}, x1, 1'b0} + {{3{x2[SW-1]}}, x2};
    fsum = $signed({10'b0, nominal_freq}) + $signed({{2{integ[31]}}, integ});
    if (fsum[33:31] == {3{fsum[31]}}) begin
      fo = fsum[31:0];
    end else begin
      fo = fsum[33] ? 32'sh80000000 : 32'sh7fffffff;
    end

    unique case (op.a)
      sspll_pkg::A_B0:   mac_a = {osg_b0[31], osg_b0};
      sspll_pkg::A_A1:   mac_a = {osg_a1[31], osg_a1};
      sspll_pkg::A_A2:   mac_a = {osg_a2[31], osg_a2};
      sspll_pkg::A_QB0:  mac_a = {osg_qb0[31], osg_qb0};
      sspll_pkg::A_COS:  mac_a = {{(OPW-SW){cosine_reg[SW-1]}}, cosine_reg};
      sspll_pkg::A_SIN:  mac_a = {{(OPW-SW){sine_reg[SW-1]}}, sine_reg};
      sspll_pkg::A_LB0:  mac_a = {loop_b0[31], loop_b0};
      sspll_pkg::A_LB1:  mac_a = {loop_b1[31], loop_b1};
      sspll_pkg::A_FREQ: mac_a = {fo[31], fo};
      default:           mac_a = '0;
    endcase

    unique case (op.b)
      sspll_pkg::B_XDIFF: mac_b = {{(OPW-SW-1){xdiff[SW]}}, xdiff};
      sspll_pkg::B_XSUM:  mac_b = {{(OPW-SW-3){xsum[SW+2]}}, xsum};
      sspll_pkg::B_AH0:   mac_b = {ah0[31], ah0};
      sspll_pkg::B_AH1:   mac_b = {ah1[31], ah1};
      sspll_pkg::B_BH0:   mac_b = {bh0[31], bh0};
      sspll_pkg::B_BH1:   mac_b = {bh1[31], bh1};
      sspll_pkg::B_Q:     mac_b = {q_reg[31], q_reg};
      sspll_pkg::B_PQ:    mac_b = {prev_q[31], prev_q};
      sspll_pkg::B_TS:    mac_b = {1'b0, time_step};
      default:            mac_b = '0;
    endcase

    unique case (op.init)
      sspll_pkg::INIT_INTEG: mac_init = {{3{integ[31]}}, integ};
      sspll_pkg::INIT_PHASE: mac_init = {3'b000, phase_acc};
      default:               mac_init = '0;
    endcase
  end

  sspll_mac u_mac (
    .clk     (clk),
    .mul_en  (state == MUL),
    .acc_en  (state == ACC),
    .ctl     (op.ctl),
    .a       (mac_a),
    .b       (mac_b),
    .init    (mac_init),
    .sum_sat (sum_sat),
    .sum_low (sum_low)
  );

  assign cord_start = (state == ACC) && (op.dst == sspll_pkg::DST_PHASE);

  sspll_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cord_start),
    .phase  (sum_low),
    .done   (cord_done),
    .sine   (cord_sin),
    .cosine (cord_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      op_idx <= '0;
      out_valid <= 1'b0;
      osg_b0 <= '0; osg_a1 <= '0; osg_a2 <= '0; osg_qb0 <= '0;
      loop_b0 <= '0; loop_b1 <= '0;
      nominal_freq <= 24'd3276800;
      time_step <= 32'd429497;
      x0 <= '0; x1 <= '0; x2 <= '0;
      ah0 <= '0; ah1 <= '0; bh0 <= '0; bh1 <= '0;
      q_reg <= '0; d_reg <= '0; prev_q <= '0; integ <= '0;
      phase_acc <= '0; sine_reg <= '0; cosine_reg <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sspll_pkg::REG_OSG_B0:    osg_b0 <= cfg_data;
          sspll_pkg::REG_OSG_A1:    osg_a1 <= cfg_data;
          sspll_pkg::REG_OSG_A2:    osg_a2 <= cfg_data;
          sspll_pkg::REG_OSG_QB0:   osg_qb0 <= cfg_data;
          sspll_pkg::REG_LOOP_B0:   loop_b0 <= cfg_data;
          sspll_pkg::REG_LOOP_B1:   loop_b1 <= cfg_data;
          sspll_pkg::REG_NOM_FREQ:  nominal_freq <= cfg_data[23:0];
          sspll_pkg::REG_TIME_STEP: time_step <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            x0 <= grid_sample;
            op_idx <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          state <= ACC;
        end
        ACC: begin
          unique case (op.dst)
            sspll_pkg::DST_ALPHA: begin
              ah1 <= ah0;
              ah0 <= sum_sat;
            end
            sspll_pkg::DST_BETA: begin
              bh1 <= bh0;
              bh0 <= sum_sat;
              // Both numerators have used the sample history by now.
              x2 <= x1;
              x1 <= x0;
            end
            sspll_pkg::DST_Q:     q_reg <= sum_sat;
            sspll_pkg::DST_D:     d_reg <= sum_sat;
            sspll_pkg::DST_INTEG: begin
              integ <= sum_sat;
              prev_q <= q_reg;
            end
            sspll_pkg::DST_PHASE: phase_acc <= sum_low;
            default: ;
          endcase
          if (op.dst == sspll_pkg::DST_PHASE) begin
            state <= CORD;
          end else begin
            op_idx <= op_idx + 1'b1;
            state <= MUL;
          end
        end
        CORD: begin
          if (cord_done) begin
            sine_reg <= cord_sin;
            cosine_reg <= cord_cos;
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            alpha_out <= ah0;
            beta_out <= bh0;
            d_term <= d_reg;
            q_term <= q_reg;
            freq_out <= fo;
            phase_out <= phase_acc;
            sine_out <= sine_reg;
            cosine_out <= cosine_reg;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
